@@ src/uulf_pkg.sv @@
// ----------------------------------------------------------------------------
// uulf_pkg
// Shared types and constants of the uuencode line framer: line job record,
// line store write port, encoder states and character codes.
// ----------------------------------------------------------------------------
package uulf_pkg;

    // field widths
    localparam int LEN_W   = 6;
    localparam int LPC_W   = 5;
    localparam int SUM_W   = 18;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int BCD_DIGITS = 6;
    localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);

    // line job queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [7:0] CHAR_BIAS  = 8'd32;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // register map and reset values
    localparam logic REG_BPL = 1'b0;
    localparam logic REG_LPC = 1'b1;
    localparam logic [LEN_W-1:0] BPL_RESET = 6'd45;
    localparam logic [LPC_W-1:0] LPC_RESET = 5'd20;

    // one closed line waiting to be sent
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] n;
        logic             chk;
        logic [SUM_W-1:0] sum;
    } t_job;

    // line store write from the front
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } t_mem_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_LF1,
        ST_DIG,
        ST_CR2,
        ST_LF2
    } t_enc_state;

endpackage

@@ src/uulf_front.sv @@
// ----------------------------------------------------------------------------
// uulf_front
// Accepts raw bytes, writes them to the current line bank, keeps the running
// sum and line count, and queues a job when a line closes.
// ----------------------------------------------------------------------------
module uulf_front #(
    parameter int MAX_LINE_BYTES = 45
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_final_byte,
    input  logic [uulf_pkg::LEN_W-1:0] i_bpl,
    input  logic [uulf_pkg::LPC_W-1:0] i_lpc,
    input  logic                     i_full,
    output logic                     o_push,
    output uulf_pkg::t_job           o_job,
    output uulf_pkg::t_mem_wr        o_wr
);
    import uulf_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE_BYTES);

    logic [LEN_W-1:0] r_bil;
    logic [LPC_W-1:0] r_lss;
    logic [SUM_W-1:0] r_sum;
    logic             r_bank;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] cnt_inc;
    logic [LPC_W-1:0] lss_inc;
    logic [SUM_W-1:0] sum_inc;
    logic             accept;
    logic             close;
    logic             chk;

    // both banks busy means the next byte has nowhere to go
    assign o_stall = i_full;
    assign accept  = i_valid & ~i_full;

    // line length clamped to 1..MAX_LINE_BYTES
    always_comb begin
        if (i_bpl == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_bpl > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = i_bpl;
        end
    end

    assign cnt_inc = r_bil + LEN_W'(1);
    assign lss_inc = r_lss + LPC_W'(1);
    assign sum_inc = r_sum + SUM_W'(i_data_byte);
    assign close   = (cnt_inc >= eff_len) | i_final_byte;
    assign chk     = i_final_byte | (lss_inc >= i_lpc);

    // store write and job record
    always_comb begin
        o_wr.en    = accept;
        o_wr.bank  = r_bank;
        o_wr.idx   = r_bil;
        o_wr.data  = i_data_byte;
        o_job.bank = r_bank;
        o_job.n    = cnt_inc;
        o_job.chk  = chk;
        o_job.sum  = sum_inc;
        o_push     = accept & close;
    end

    // line and checksum counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bil  <= '0;
            r_lss  <= '0;
            r_sum  <= '0;
            r_bank <= 1'b0;
        end else if (accept) begin
            if (close) begin
                r_bil  <= '0;
                r_bank <= ~r_bank;
                r_lss  <= chk ? '0 : lss_inc;
                r_sum  <= chk ? '0 : sum_inc;
            end else begin
                r_bil  <= cnt_inc;
                r_sum  <= sum_inc;
            end
        end
    end

endmodule

@@ src/uulf_fifo.sv @@
// ----------------------------------------------------------------------------
// uulf_fifo
// Short queue of closed line jobs between the front and the encoder.
// ----------------------------------------------------------------------------
module uulf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uulf_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_vld,
    output logic           o_full,
    output uulf_pkg::t_job o_head
);
    import uulf_pkg::*;

    t_job                  r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_head = r_buf[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/uulf_bcd.sv @@
// ----------------------------------------------------------------------------
// uulf_bcd
// Binary to decimal converter for the checksum, one shift-and-adjust step
// per cycle, with the index of the most significant nonzero digit.
// ----------------------------------------------------------------------------
module uulf_bcd (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [uulf_pkg::SUM_W-1:0]   i_value,
    output logic                         o_done,
    output logic [3:0]                   o_digits [uulf_pkg::BCD_DIGITS],
    output logic [uulf_pkg::DIG_IDX_W-1:0] o_msd
);
    import uulf_pkg::*;

    logic [SUM_W-1:0]        r_bin;
    logic [4*BCD_DIGITS-1:0] r_bcd;
    logic [STEP_W-1:0]       r_step;
    logic                    r_busy;
    logic                    r_done;
    logic [4*BCD_DIGITS-1:0] adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // conversion steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[SUM_W-2:0], 1'b0};
            r_bcd <= {adj[4*BCD_DIGITS-2:0], r_bin[SUM_W-1]};
        end
    end

    // digit view and leading zero search
    always_comb begin
        o_msd = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            o_digits[i] = r_bcd[4*i +: 4];
            if (r_bcd[4*i +: 4] != 4'd0) begin
                o_msd = DIG_IDX_W'(i);
            end
        end
    end

    assign o_done = r_done;

endmodule

@@ src/uulf_back.sv @@
// ----------------------------------------------------------------------------
// uulf_back
// Line encoder: holds the two line banks, walks a queued job one character
// per cycle while the output is not stalled (length, 6-bit groups, CR LF,
// checksum digits, CR LF) and packs the characters into output pairs.
// ----------------------------------------------------------------------------
module uulf_back #(
    parameter int MAX_LINE_BYTES = 45
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uulf_pkg::t_mem_wr i_wr,
    input  logic              i_job_vld,
    input  uulf_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_char_first,
    output logic [7:0]        o_char_second,
    output logic              o_pair_full,
    output logic              o_run_end
);
    import uulf_pkg::*;

    localparam int DEPTH  = 2 * MAX_LINE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    // line store, two banks
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_q;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    t_enc_state r_state;
    t_enc_state n_state;
    t_job       r_job;

    logic [LEN_W-1:0]     r_rd_idx;
    logic                 r_q_vld;
    logic [11:0]          r_acc;
    logic [3:0]           r_cnt;
    logic [DIG_IDX_W-1:0] r_di;
    logic                 r_di_vld;

    // pair assembly and output register
    logic       r_half_vld;
    logic [7:0] r_half;
    logic       r_out_vld;
    logic [7:0] r_out_first;
    logic [7:0] r_out_second;
    logic       r_out_full;
    logic       r_out_end;

    // character stream
    logic       ch_vld;
    logic [7:0] ch_char;
    logic       ch_last;
    logic       ch_rdy;
    logic       adv;
    logic       consume;
    logic       is_cr;
    logic [11:0] n_acc;
    logic [3:0]  n_cnt;

    logic                 more;
    logic                 all_done;
    logic [11:0]          merged;
    logic [3:0]           cnt_m;
    logic [11:0]          shifted;
    logic [DIG_IDX_W-1:0] cur_di;
    logic                 load;

    logic                 bcd_done;
    logic [3:0]           bcd_digits [BCD_DIGITS];
    logic [DIG_IDX_W-1:0] bcd_msd;

    uulf_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (load & i_job.chk),
        .i_value  (i_job.sum),
        .o_done   (bcd_done),
        .o_digits (bcd_digits),
        .o_msd    (bcd_msd)
    );

    assign wr_addr = i_wr.bank ? ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(i_wr.idx)
                               : ADDR_W'(i_wr.idx);
    assign rd_addr = r_job.bank ? ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(r_rd_idx)
                                : ADDR_W'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    // byte fetch and group arithmetic
    assign load     = (r_state == ST_IDLE) & i_job_vld;
    assign more     = (r_rd_idx < r_job.n);
    assign all_done = (r_rd_idx == r_job.n) & ~r_q_vld;
    assign merged   = {r_acc[3:0], r_q};
    assign cnt_m    = r_cnt + 4'd8;
    assign shifted  = merged >> (cnt_m - 4'd6);
    assign cur_di   = r_di_vld ? r_di : bcd_msd;

    assign ch_rdy  = (~r_half_vld & ~ch_last) | ~r_out_vld | ~i_stall;
    assign adv     = ch_vld & ch_rdy;
    assign consume = adv & (r_state == ST_DATA) & (r_cnt < 4'd6) & r_q_vld;
    assign rd_en   = ((r_state == ST_LEN) | (r_state == ST_DATA)) & more
                     & (~r_q_vld | consume);
    assign o_pop   = adv & ch_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_job_vld) n_state = ST_LEN;
            ST_LEN:  if (adv) n_state = ST_DATA;
            ST_DATA: if (adv & is_cr) n_state = ST_LF1;
            ST_LF1:  if (adv) n_state = r_job.chk ? ST_DIG : ST_IDLE;
            ST_DIG:  if (adv & (cur_di == '0)) n_state = ST_CR2;
            ST_CR2:  if (adv) n_state = ST_LF2;
            ST_LF2:  if (adv) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // character produced in each state
    always_comb begin
        ch_vld  = 1'b0;
        ch_char = CHAR_CR;
        ch_last = 1'b0;
        is_cr   = 1'b0;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                ch_vld = 1'b0;
            end
            ST_LEN: begin
                ch_vld  = 1'b1;
                ch_char = CHAR_BIAS + {2'b00, r_job.n};
            end
            ST_DATA: begin
                if (r_cnt >= 4'd6) begin
                    ch_vld  = 1'b1;
                    ch_char = CHAR_BIAS + {2'b00, r_acc[5:0]};
                    n_cnt   = 4'd0;
                end else if (r_q_vld) begin
                    ch_vld  = 1'b1;
                    ch_char = CHAR_BIAS + {2'b00, shifted[5:0]};
                    n_acc   = merged;
                    n_cnt   = cnt_m - 4'd6;
                end else if (all_done & (r_cnt != 4'd0)) begin
                    // partial last group, left aligned
                    ch_vld = 1'b1;
                    case (r_cnt)
                        4'd2:    ch_char = CHAR_BIAS + {2'b00, r_acc[1:0], 4'b0000};
                        4'd4:    ch_char = CHAR_BIAS + {2'b00, r_acc[3:0], 2'b00};
                        default: ch_char = CHAR_BIAS + {2'b00, r_acc[5:0]};
                    endcase
                    n_cnt = 4'd0;
                end else if (all_done) begin
                    ch_vld  = 1'b1;
                    ch_char = CHAR_CR;
                    is_cr   = 1'b1;
                end
            end
            ST_LF1: begin
                ch_vld  = 1'b1;
                ch_char = CHAR_LF;
                ch_last = ~r_job.chk;
            end
            ST_DIG: begin
                ch_vld  = bcd_done;
                ch_char = CHAR_ZERO + {4'd0, bcd_digits[cur_di]};
            end
            ST_CR2: begin
                ch_vld  = 1'b1;
                ch_char = CHAR_CR;
            end
            ST_LF2: begin
                ch_vld  = 1'b1;
                ch_char = CHAR_LF;
                ch_last = 1'b1;
            end
            default: begin
                ch_vld = 1'b0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_q_vld  <= 1'b0;
            r_rd_idx <= '0;
            r_cnt    <= '0;
            r_di_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_job    <= i_job;
                r_rd_idx <= '0;
                r_q_vld  <= 1'b0;
                r_cnt    <= '0;
                r_di_vld <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + LEN_W'(1);
                    r_q_vld  <= 1'b1;
                end else if (consume) begin
                    r_q_vld  <= 1'b0;
                end
                if (adv & (r_state == ST_DATA)) begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
                if (adv & (r_state == ST_DIG)) begin
                    r_di     <= cur_di - DIG_IDX_W'(1);
                    r_di_vld <= 1'b1;
                end
            end
        end
    end

    // pair packing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (adv & (r_half_vld | ch_last)) begin
                // a pair completes, or a lone character closes the run
                r_out_vld    <= 1'b1;
                r_out_first  <= r_half_vld ? r_half : ch_char;
                r_out_second <= r_half_vld ? ch_char : 8'd0;
                r_out_full   <= r_half_vld;
                r_out_end    <= ch_last;
                r_half_vld   <= 1'b0;
            end else begin
                if (r_out_vld & ~i_stall) begin
                    r_out_vld <= 1'b0;
                end
                if (adv) begin
                    r_half     <= ch_char;
                    r_half_vld <= 1'b1;
                end
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_char_first  = r_out_first;
    assign o_char_second = r_out_second;
    assign o_pair_full   = r_out_full;
    assign o_run_end     = r_out_end;

endmodule

@@ src/uuencode_line_framer.sv @@
// ----------------------------------------------------------------------------
// uuencode_line_framer
// Packs raw bytes into uuencoded text lines with a decimal checksum line.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one raw byte per item plus a final flag.
// Output channel (o_valid / i_stall): one character pair per item; run_end
// marks the last pair caused by one input byte, pair_full 0 marks a lone
// first character (second reads 0).
// Configuration (APB, pready always high): byte 0 bytes_per_line, byte 4
// lines_per_checksum; the user must write them only while the block is idle,
// which the block itself does not enforce. Bytes are taken one per cycle,
// while o_stall is low, into a two-bank line store; o_stall rises only while
// both banks hold lines not yet sent. The encoder sends one character per
// cycle while the output is not stalled, two characters to a pair: a line
// sends its length character, its 6-bit groups and CR LF, and a checksum
// adds its digits, once converted, and CR LF; the decimal conversion starts
// when the line's job is taken up by the encoder.
// A stalled receiver holds the output pair; the encoder then stops, and the
// front keeps taking bytes until both banks are full.
// Reset clears counters, sum, queue and output valid; the line store needs
// no clearing since only bytes of the current line are read.
// ----------------------------------------------------------------------------
module uuencode_line_framer #(
    parameter int MAX_LINE_BYTES = 45
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_char_first,
    output logic [7:0]  o_char_second,
    output logic        o_pair_full,
    output logic        o_run_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uulf_pkg::*;

    logic [LEN_W-1:0] r_bpl;
    logic [LPC_W-1:0] r_lpc;
    logic             cfg_wr;

    logic    push;
    logic    pop;
    logic    q_vld;
    logic    q_full;
    t_job    job_in;
    t_job    job_head;
    t_mem_wr mem_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl <= BPL_RESET;
            r_lpc <= LPC_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BPL: r_bpl <= pwdata[LEN_W-1:0];
                REG_LPC: r_lpc <= pwdata[LPC_W-1:0];
                default: r_bpl <= r_bpl;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BPL: prdata = {{(32-LEN_W){1'b0}}, r_bpl};
            REG_LPC: prdata = {{(32-LPC_W){1'b0}}, r_lpc};
            default: prdata = '0;
        endcase
    end

    uulf_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_bpl        (r_bpl),
        .i_lpc        (r_lpc),
        .i_full       (q_full),
        .o_push       (push),
        .o_job        (job_in),
        .o_wr         (mem_wr)
    );

    uulf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_full  (q_full),
        .o_head  (job_head)
    );

    uulf_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (mem_wr),
        .i_job_vld     (q_vld),
        .i_job         (job_head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_first  (o_char_first),
        .o_char_second (o_char_second),
        .o_pair_full   (o_pair_full),
        .o_run_end     (o_run_end)
    );

endmodule

@@ src/uulf_checker.sv @@
// ----------------------------------------------------------------------------
// uulf_checker
// Port-level checks of the line framer, bound to the top level.
// ----------------------------------------------------------------------------
module uulf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_char_first,
    input logic [7:0]  o_char_second,
    input logic        o_pair_full,
    input logic        o_run_end
);
    import uulf_pkg::*;

    // nothing is offered and nothing is stalled right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    // a stalled pair holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_first)
            && $stable(o_char_second) && $stable(o_pair_full) && $stable(o_run_end))
        else $error("stalled pair changed");

    // a lone character only closes a run, and then its partner is zero
    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pair_full |-> o_run_end && (o_char_second == 8'd0))
        else $error("half pair inside a run");

    // every run ends in a line feed
    a_run_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_end |->
            (o_pair_full && (o_char_second == CHAR_LF))
            || (!o_pair_full && (o_char_first == CHAR_LF)))
        else $error("run does not end in line feed");

endmodule

bind uuencode_line_framer uulf_checker u_uulf_checker (.*);

@@ sim/uulf_checker.sv @@
// ----------------------------------------------------------------------------
// uulf_scoreboard
// Scoreboard for the uuencode line framer: watches the byte channel, the
// pair channel and register writes, predicts every character pair and
// compares each delivered pair field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module uulf_scoreboard #(
    parameter int MAX_LINE_BYTES = 45
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_char_first,
    input  logic [7:0]  i_char_second,
    input  logic        i_pair_full,
    input  logic        i_run_end,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_seen,
    output int          o_lines_seen,
    output int          o_sums_seen,
    output int          o_pairs_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import uulf_pkg::*;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       full;
        logic       last;
    } t_pair;

    t_pair            pair_q [$];
    logic [LEN_W-1:0] bpl_reg;
    logic [LPC_W-1:0] lpc_reg;
    logic [7:0]       line_buf [MAX_LINE_BYTES];
    logic [LEN_W-1:0] line_fill;
    logic [LPC_W-1:0] lines_open;
    logic [SUM_W-1:0] sum_acc;
    int               fail_cnt;
    int               bytes_cnt;
    int               lines_cnt;
    int               sums_cnt;
    int               pairs_cnt;

    // take one byte into the line model and queue the pairs it causes
    task automatic frame_byte(input logic [7:0] b, input logic fin);
        logic [7:0]       stream [$];
        logic [7:0]       digits [$];
        logic [LEN_W-1:0] lim;
        logic [13:0]      acc;
        logic [13:0]      tmp;
        logic [5:0]       grp;
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] rem;
        int               bits;
        t_pair            pr;
        lim = bpl_reg;
        if (lim == 0) lim = LEN_W'(1);
        if (lim > MAX_LINE_BYTES) lim = LEN_W'(MAX_LINE_BYTES);
        if (line_fill < MAX_LINE_BYTES) begin
            line_buf[line_fill] = b;
            line_fill = line_fill + 1'b1;
        end
        sum_acc = sum_acc + b;
        bytes_cnt++;
        if (line_fill >= lim || fin) begin
            // length character, 6-bit groups, partial group, line end
            stream.push_back({2'b00, line_fill} + CHAR_BIAS);
            acc  = '0;
            bits = 0;
            for (int i = 0; i < line_fill; i++) begin
                acc  = {acc[5:0], line_buf[i]};
                bits = bits + 8;
                while (bits >= 6) begin
                    bits = bits - 6;
                    tmp  = acc >> bits;
                    grp  = tmp[5:0];
                    stream.push_back({2'b00, grp} + CHAR_BIAS);
                end
                acc = acc & ((14'd1 << bits) - 14'd1);
            end
            if (bits > 0) begin
                tmp = acc << (6 - bits);
                grp = tmp[5:0];
                stream.push_back({2'b00, grp} + CHAR_BIAS);
            end
            stream.push_back(CHAR_CR);
            stream.push_back(CHAR_LF);
            line_fill  = '0;
            lines_open = lines_open + 1'b1;
            lines_cnt++;
            // decimal checksum line, no leading zeros
            if (fin || lines_open >= lpc_reg) begin
                v = sum_acc;
                do begin
                    rem = v % SUM_W'(10);
                    digits.push_front(CHAR_ZERO + {4'b0000, rem[3:0]});
                    v = v / SUM_W'(10);
                end while (v != 0);
                foreach (digits[j]) stream.push_back(digits[j]);
                stream.push_back(CHAR_CR);
                stream.push_back(CHAR_LF);
                sum_acc    = '0;
                lines_open = '0;
                sums_cnt++;
            end
            // split the stream into pairs
            for (int a = 0; a < stream.size(); a += 2) begin
                pr.full   = (a + 1) < stream.size();
                pr.first  = stream[a];
                pr.second = pr.full ? stream[a + 1] : 8'h00;
                pr.last   = (a + 2) >= stream.size();
                pair_q.push_back(pr);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pair exp_pair;
        if (!i_rst_n) begin
            pair_q.delete();
            bpl_reg    = BPL_RESET;
            lpc_reg    = LPC_RESET;
            line_fill  = '0;
            lines_open = '0;
            sum_acc    = '0;
            fail_cnt   = 0;
            bytes_cnt  = 0;
            lines_cnt  = 0;
            sums_cnt   = 0;
            pairs_cnt  = 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_BPL) bpl_reg = i_pwdata[LEN_W-1:0];
                else lpc_reg = i_pwdata[LPC_W-1:0];
            end
            // accepted byte
            if (i_in_valid && !i_in_stall) frame_byte(i_data_byte, i_final_byte);
            // accepted pair
            if (i_out_valid && !i_out_stall) begin
                pairs_cnt++;
                if (pair_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("pair with none expected: %02h %02h full %b end %b",
                                 i_char_first, i_char_second, i_pair_full, i_run_end);
                end else begin
                    exp_pair = pair_q.pop_front();
                    if (i_char_first !== exp_pair.first ||
                        i_char_second !== exp_pair.second ||
                        i_pair_full !== exp_pair.full || i_run_end !== exp_pair.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"pair %0d mismatch: exp %02h %02h full %b end %b,",
                                      " got %02h %02h full %b end %b"},
                                     pairs_cnt, exp_pair.first, exp_pair.second,
                                     exp_pair.full, exp_pair.last, i_char_first,
                                     i_char_second, i_pair_full, i_run_end);
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= pair_q.size();
        o_bytes_seen <= bytes_cnt;
        o_lines_seen <= lines_cnt;
        o_sums_seen  <= sums_cnt;
        o_pairs_seen <= pairs_cnt;
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the uuencode line framer: directed lines covering field
// extremes and line-closing corner cases, then random byte bursts under
// several register settings, one of them with no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uulf_pkg::*;

    localparam int MAX_LINE_BYTES = 45;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_PCT       = 27;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_data   = 8'h00;
    logic        in_final  = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic        pair_full;
    logic        run_end;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic        calm      = 1'b0;
    int          quiet_cycles = 0;
    int          cfg_count = 0;
    int          fail_count;
    int          pending;
    int          bytes_seen;
    int          lines_seen;
    int          sums_seen;
    int          pairs_seen;

    uuencode_line_framer #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_data_byte(in_data),
        .i_final_byte(in_final),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_char_first(char_first),
        .o_char_second(char_second),
        .o_pair_full(pair_full),
        .o_run_end(run_end),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    uulf_scoreboard #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_data_byte(in_data),
        .i_final_byte(in_final),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_char_first(char_first),
        .i_char_second(char_second),
        .i_pair_full(pair_full),
        .i_run_end(run_end),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_pready(pready),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_bytes_seen(bytes_seen),
        .o_lines_seen(lines_seen),
        .o_sums_seen(sums_seen),
        .o_pairs_seen(pairs_seen)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n || calm) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d pairs outstanding",
                     quiet_cycles, pending);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one byte with random gaps; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_final <= fin;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // wait for every pair, then let the block go quiet
    task automatic settle();
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits are random junk the register must ignore
    task automatic set_config(input logic [LEN_W-1:0] bpl, input logic [LPC_W-1:0] lpc);
        logic [31:0] w;
        settle();
        w = $urandom();
        w[LEN_W-1:0] = bpl;
        reg_write(REG_BPL, w);
        w = $urandom();
        w[LPC_W-1:0] = lpc;
        reg_write(REG_LPC, w);
        cfg_count++;
    endtask

    initial begin
        logic [7:0]       b;
        logic [LEN_W-1:0] bpl;
        logic [LPC_W-1:0] lpc;
        logic [LEN_W-1:0] bpl_tab [4];
        logic [LPC_W-1:0] lpc_tab [4];
        bpl_tab = '{6'd45, 6'd1, 6'd0, 6'd7};
        lpc_tab = '{5'd31, 5'd1, 5'd0, 5'd3};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: short line closed by the final flag, then a one-byte line
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b1);
        in_valid <= 1'b0;

        // three-byte lines, checksum every second line, final byte fills a line
        set_config(6'd3, 5'd2);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h3C, 1'b1);
        in_valid <= 1'b0;

        // zero line length and zero line count act as one
        set_config(6'd0, 5'd0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hEF, 1'b0);
        in_valid <= 1'b0;

        // oversized line length, then lowered below the bytes already held
        set_config(6'd63, 5'd31);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        in_valid <= 1'b0;
        set_config(6'd2, 5'd31);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hBC, 1'b1);
        in_valid <= 1'b0;

        // zero checksum prints a single digit
        set_config(6'd45, 5'd20);
        send_byte(8'h00, 1'b1);
        in_valid <= 1'b0;

        // random bursts under fixed and random settings; phase 3 runs with no idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) begin
                bpl = bpl_tab[ph];
                lpc = lpc_tab[ph];
            end else begin
                bpl = LEN_W'($urandom_range(63));
                lpc = LPC_W'($urandom_range(31));
            end
            set_config(bpl, lpc);
            calm = (ph == 3);
            for (int n = 0; n < ((ph == 3) ? 36 : 18); n++) begin
                case ($urandom_range(3))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom());
                endcase
                send_byte(b, $urandom_range(99) < 4);
            end
            in_valid <= 1'b0;
        end
        calm = 1'b0;

        // drain and verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d bytes in %0d lines with %0d checksum lines over %0d settings",
                 bytes_seen, lines_seen, sums_seen, cfg_count);
        $display("compared %0d character pairs, %0d mismatches", pairs_seen, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
